### rtl/core/gm4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gm4_pkg
// Shared types and constants of the four-point geometric median block.
// ----------------------------------------------------------------------------
package gm4_pkg;

  localparam int NumPts = 4;
  localparam int CqDepth = 4;
  localparam int CqPtrW = $clog2(CqDepth);
  localparam int CqCntW = $clog2(CqDepth + 1);

  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam logic signed [31:0] Q_POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_NEG_MAX = 32'sh8000_0000;

  // One candidate point, together with the item's four points.
  typedef struct packed {
    logic [NumPts-1:0][15:0] px;
    logic [NumPts-1:0][15:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic last;
  } cand_t;

endpackage
`default_nettype wire

### rtl/core/gm4_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gm4_div
// Restoring divider, one quotient bit per cycle, signed Q16.16 saturating.
// ----------------------------------------------------------------------------
module gm4_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [58:0]        num,
  input  wire logic [34:0]        den,
  input  wire logic               neg,
  output logic                    busy,
  output logic signed [31:0]      quot
);

  logic [58:0] rem;
  logic [64:0] dsh;
  logic [30:0] q;
  logic [4:0]  cnt;
  logic        sat;
  logic        sgn;
  logic        ge;

  assign ge = {7'b0, rem} >= {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, 30'b0};
      q   <= '0;
      cnt <= 5'd30;
      sgn <= neg;
      sat <= {8'b0, num} >= {1'b0, den, 31'b0};
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[58:0];
      end
      q   <= {q[29:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - 5'd1;
    end
  end

  always_comb begin
    if (sat) begin
      quot = sgn ? gm4_pkg::Q_NEG_MAX : gm4_pkg::Q_POS_MAX;
    end else if (sgn) begin
      quot = -$signed({1'b0, q});
    end else begin
      quot = $signed({1'b0, q});
    end
  end

endmodule
`default_nettype wire

### rtl/core/gm4_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gm4_front
// Accepts four points and produces the seven candidate points in order.
// ----------------------------------------------------------------------------
module gm4_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [15:0]       pa_x,
  input  wire logic [15:0]       pa_y,
  input  wire logic [15:0]       pb_x,
  input  wire logic [15:0]       pb_y,
  input  wire logic [15:0]       pc_x,
  input  wire logic [15:0]       pc_y,
  input  wire logic [15:0]       pd_x,
  input  wire logic [15:0]       pd_y,
  output logic                   q_push,
  input  wire logic              q_full,
  output gm4_pkg::cand_t         q_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_PTS  = 3'd1;
  localparam logic [2:0] F_LINE = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_SUB  = 3'd4;
  localparam logic [2:0] F_DIV  = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0] state;
  logic [1:0] pt;
  logic [1:0] pair;
  logic [gm4_pkg::NumPts-1:0][15:0] ptx;
  logic [gm4_pkg::NumPts-1:0][15:0] pty;
  logic signed [31:0] cx;
  logic signed [31:0] cy;

  logic signed [15:0] xi, yi, xj, yj, xk, yk, xl, yl;
  logic signed [16:0] a1, b1, a2, b2;
  logic signed [31:0] m1, m2, m3, m4;
  logic signed [32:0] c1, c2;
  logic signed [49:0] pb1c2, pb2c1, pa2c1, pa1c2;
  logic signed [33:0] pa1b2, pa2b1;
  logic signed [34:0] det;
  logic signed [50:0] nx, ny;
  logic [50:0] nx_mag, ny_mag;
  logic [34:0] det_mag;
  logic div_start;
  logic div_busy_x, div_busy_y;
  logic signed [31:0] qx, qy;
  logic [15:0] sel_x, sel_y;

  always_comb begin
    case (pair)
      2'd1: begin
        xi = ptx[0]; yi = pty[0]; xj = ptx[2]; yj = pty[2];
        xk = ptx[1]; yk = pty[1]; xl = ptx[3]; yl = pty[3];
      end
      2'd2: begin
        xi = ptx[0]; yi = pty[0]; xj = ptx[3]; yj = pty[3];
        xk = ptx[1]; yk = pty[1]; xl = ptx[2]; yl = pty[2];
      end
      default: begin
        xi = ptx[0]; yi = pty[0]; xj = ptx[1]; yj = pty[1];
        xk = ptx[2]; yk = pty[2]; xl = ptx[3]; yl = pty[3];
      end
    endcase
  end

  assign c1 = 33'(m1) - 33'(m2);
  assign c2 = 33'(m3) - 33'(m4);
  assign det = 35'(pa1b2) - 35'(pa2b1);
  assign nx = 51'(pb1c2) - 51'(pb2c1);
  assign ny = 51'(pa2c1) - 51'(pa1c2);
  assign nx_mag = nx[50] ? 51'(-nx) : 51'(nx);
  assign ny_mag = ny[50] ? 51'(-ny) : 51'(ny);
  assign det_mag = det[34] ? 35'(-det) : 35'(det);
  assign div_start = (state == F_SUB) && (det != '0);

  gm4_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start),
    .num({nx_mag, 8'b0}), .den(det_mag), .neg(nx[50] ^ det[34]),
    .busy(div_busy_x), .quot(qx)
  );

  gm4_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start),
    .num({ny_mag, 8'b0}), .den(det_mag), .neg(ny[50] ^ det[34]),
    .busy(div_busy_y), .quot(qy)
  );

  assign sel_x = ptx[pt];
  assign sel_y = pty[pt];
  assign full = (state != F_IDLE);
  assign q_push = !q_full && (state == F_PTS || state == F_PUSH);

  always_comb begin
    q_data.px = ptx;
    q_data.py = pty;
    if (state == F_PTS) begin
      q_data.cx = $signed({{8{sel_x[15]}}, sel_x, 8'b0});
      q_data.cy = $signed({{8{sel_y[15]}}, sel_y, 8'b0});
      q_data.last = 1'b0;
    end else begin
      q_data.cx = cx;
      q_data.cy = cy;
      q_data.last = (pair == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pt <= '0;
      pair <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_PTS;
            pt <= '0;
          end
        end
        F_PTS: begin
          if (!q_full) begin
            pt <= pt + 2'd1;
            if (pt == 2'd3) begin
              state <= F_LINE;
              pair <= '0;
            end
          end
        end
        F_LINE: state <= F_MUL;
        F_MUL:  state <= F_SUB;
        F_SUB: begin
          state <= (det == '0) ? F_PUSH : F_DIV;
        end
        F_DIV: begin
          if (!div_busy_x && !div_busy_y) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            if (pair == 2'd2) begin
              state <= F_IDLE;
            end else begin
              pair <= pair + 2'd1;
              state <= F_LINE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      ptx <= {pd_x, pc_x, pb_x, pa_x};
      pty <= {pd_y, pc_y, pb_y, pa_y};
    end
    if (state == F_LINE) begin
      a1 <= 17'(yj) - 17'(yi);
      b1 <= 17'(xi) - 17'(xj);
      a2 <= 17'(yl) - 17'(yk);
      b2 <= 17'(xk) - 17'(xl);
      m1 <= 32'(xj) * 32'(yi);
      m2 <= 32'(xi) * 32'(yj);
      m3 <= 32'(xl) * 32'(yk);
      m4 <= 32'(xk) * 32'(yl);
    end
    if (state == F_MUL) begin
      pb1c2 <= 50'(b1) * 50'(c2);
      pb2c1 <= 50'(b2) * 50'(c1);
      pa2c1 <= 50'(a2) * 50'(c1);
      pa1c2 <= 50'(a1) * 50'(c2);
      pa1b2 <= 34'(a1) * 34'(b2);
      pa2b1 <= 34'(a2) * 34'(b1);
    end
    if (state == F_SUB && det == '0) begin
      cx <= '0;
      cy <= '0;
    end
    if (state == F_DIV && !div_busy_x && !div_busy_y) begin
      cx <= qx;
      cy <= qy;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gm4_cand_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gm4_cand_fifo
// Short candidate queue between the front and the back.
// ----------------------------------------------------------------------------
module gm4_cand_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gm4_pkg::cand_t wdata,
  output logic                full,
  input  wire logic           pop,
  output gm4_pkg::cand_t      rdata,
  output logic                empty
);

  gm4_pkg::cand_t mem [gm4_pkg::CqDepth];
  logic [gm4_pkg::CqPtrW-1:0] wp;
  logic [gm4_pkg::CqPtrW-1:0] rp;
  logic [gm4_pkg::CqCntW-1:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == gm4_pkg::CqCntW'(gm4_pkg::CqDepth));
  assign empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + gm4_pkg::CqPtrW'(1);
      end
      if (do_pop) begin
        rp <= rp + gm4_pkg::CqPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + gm4_pkg::CqCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - gm4_pkg::CqCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gm4_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gm4_back
// Sums the four distances of each candidate and keeps the least sum.
// ----------------------------------------------------------------------------
module gm4_back (
  input  wire logic           clk,
  input  wire logic           rst,
  output logic                q_pop,
  input  wire logic           q_empty,
  input  wire gm4_pkg::cand_t q_data,
  output logic                empty,
  input  wire logic           pop,
  output logic [31:0]         min_total_distance
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIFF = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_ACC  = 3'd4;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t cur, input logic [1:0] bits);
    logic [34:0] r;
    logic [34:0] t;
    sq_t o;
    r = {cur.rem[32:0], bits};
    t = {1'b0, cur.root, 2'b01};
    if (r >= t) begin
      o.rem = r - t;
      o.root = {cur.root[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {cur.root[30:0], 1'b0};
    end
    return o;
  endfunction

  logic [2:0] state;
  logic [3:0] cnt;
  logic out_valid;
  logic [31:0] best;
  gm4_pkg::cand_t cur;
  logic [30:0] ux [gm4_pkg::NumPts];
  logic [30:0] uy [gm4_pkg::NumPts];
  logic far [gm4_pkg::NumPts];
  logic [63:0] sv [gm4_pkg::NumPts];
  sq_t sq [gm4_pkg::NumPts];
  sq_t sq_mid [gm4_pkg::NumPts];
  sq_t sq_end [gm4_pkg::NumPts];
  logic signed [33:0] dx [gm4_pkg::NumPts];
  logic signed [33:0] dy [gm4_pkg::NumPts];
  logic [33:0] mx [gm4_pkg::NumPts];
  logic [33:0] my [gm4_pkg::NumPts];
  logic [33:0] total;
  logic [31:0] s;
  logic [31:0] s_min;

  always_comb begin
    total = '0;
    for (int k = 0; k < gm4_pkg::NumPts; k++) begin
      dx[k] = 34'(cur.cx) - $signed({{10{cur.px[k][15]}}, cur.px[k], 8'b0});
      dy[k] = 34'(cur.cy) - $signed({{10{cur.py[k][15]}}, cur.py[k], 8'b0});
      mx[k] = dx[k][33] ? 34'(-dx[k]) : 34'(dx[k]);
      my[k] = dy[k][33] ? 34'(-dy[k]) : 34'(dy[k]);
      sq_mid[k] = sq_step(sq[k], sv[k][63:62]);
      sq_end[k] = sq_step(sq_mid[k], sv[k][61:60]);
      total = total + 34'(far[k] ? gm4_pkg::SUM_MAX : sq[k].root);
    end
    s = (total > 34'(gm4_pkg::SUM_MAX)) ? gm4_pkg::SUM_MAX : total[31:0];
    s_min = (s < best) ? s : best;
  end

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      best <= gm4_pkg::SUM_MAX;
      cnt <= '0;
    end else begin
      if (state == B_ACC && cur.last && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_DIFF;
          end
        end
        B_DIFF: state <= B_SQ;
        B_SQ: begin
          cnt <= 4'd15;
          state <= B_ROOT;
        end
        B_ROOT: begin
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= B_ACC;
          end
        end
        B_ACC: begin
          if (!cur.last) begin
            best <= s_min;
            state <= B_IDLE;
          end else if (!out_valid || pop) begin
            best <= gm4_pkg::SUM_MAX;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == B_ACC && cur.last && (!out_valid || pop)) begin
      min_total_distance <= s_min;
    end
    for (int k = 0; k < gm4_pkg::NumPts; k++) begin
      if (state == B_DIFF) begin
        ux[k] <= mx[k][30:0];
        uy[k] <= my[k][30:0];
        far[k] <= (mx[k][33:31] != 3'b0) || (my[k][33:31] != 3'b0);
      end
      if (state == B_SQ) begin
        sv[k] <= {1'b0, 63'(62'(ux[k]) * 62'(ux[k])) + 63'(62'(uy[k]) * 62'(uy[k]))};
        sq[k] <= '0;
      end
      if (state == B_ROOT) begin
        sv[k] <= {sv[k][59:0], 4'b0};
        sq[k] <= sq_end[k];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/four_point_geometric_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_point_geometric_median
// Least total distance from seven candidate points to four Q8.8 points.
// ----------------------------------------------------------------------------
// An item of four signed Q8.8 points yields one unsigned Q16.16 result, the
// least sum of distances over the four points and the three line crossings.
// The front computes the crossings with two dividers, one per coordinate,
// and the back evaluates each candidate with four square-root units that
// resolve two root bits per cycle. The back sets the sustained item rate,
// and the front takes the next item while the back is still at work on the
// last.
module four_point_geometric_median (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] pa_x,
  input  wire logic [15:0] pa_y,
  input  wire logic [15:0] pb_x,
  input  wire logic [15:0] pb_y,
  input  wire logic [15:0] pc_x,
  input  wire logic [15:0] pc_y,
  input  wire logic [15:0] pd_x,
  input  wire logic [15:0] pd_y,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      min_total_distance
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  gm4_pkg::cand_t q_wdata;
  gm4_pkg::cand_t q_rdata;

  gm4_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pa_x(pa_x), .pa_y(pa_y), .pb_x(pb_x), .pb_y(pb_y),
    .pc_x(pc_x), .pc_y(pc_y), .pd_x(pd_x), .pd_y(pd_y),
    .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  gm4_cand_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  gm4_back u_back (
    .clk(clk), .rst(rst), .q_pop(q_pop), .q_empty(q_empty), .q_data(q_rdata),
    .empty(empty), .pop(pop), .min_total_distance(min_total_distance)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("candidate transfer into a full queue");
  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("candidate transfer from an empty queue");
  a_busy: assert property (@(posedge clk) disable iff (rst) (push && !full) |=> full)
    else $error("front not busy after an input transfer");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-point geometric median block.
// ----------------------------------------------------------------------------
// A short table of directed point sets is followed by random sets, some
// clustered, some stepped from a start, some parallel. Each accepted set is
// predicted in exact integer arithmetic, and every popped result is compared
// with the oldest prediction. Push and pop idle at random in three phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumRand = 1630;

  typedef struct {
    logic [15:0] x[4];
    logic [15:0] y[4];
    bit          has_lit;
    logic [31:0] lit;
  } pts_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [15:0] pa_x = '0, pa_y = '0, pb_x = '0, pb_y = '0;
  logic [15:0] pc_x = '0, pc_y = '0, pd_x = '0, pd_y = '0;
  wire         full;
  wire         empty;
  wire  [31:0] min_total_distance;

  logic [31:0] median_q[$];
  int          err_cnt = 0;
  int          push_idle = 19;
  int          pop_idle = 59;
  bit          stim_done = 1'b0;
  pts_t        dir_tab[$];

  four_point_geometric_median u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pa_x(pa_x), .pa_y(pa_y), .pb_x(pb_x), .pb_y(pb_y),
    .pc_x(pc_x), .pc_y(pc_y), .pd_x(pd_x), .pd_y(pd_y),
    .empty(empty), .pop(pop), .min_total_distance(min_total_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint clamp_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] dist_sum(longint px[4], longint py[4],
                                           longint cx, longint cy);
    logic [63:0] acc, ux, uy, d;
    longint      dx, dy;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      dx = cx - px[k] * 256;
      dy = cy - py[k] * 256;
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) d = 64'hFFFF_FFFF;
      else d = root64(ux * ux + uy * uy);
      acc = acc + d;
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    end
    return acc;
  endfunction

  function automatic logic [31:0] least_distance(pts_t p);
    longint      px[4], py[4];
    int          pr[3][4];
    longint      a1, b1, c1, a2, b2, c2, det, cx, cy;
    logic [63:0] best, s;
    pr = '{'{0, 1, 2, 3}, '{0, 2, 1, 3}, '{0, 3, 1, 2}};
    best = 64'hFFFF_FFFF;
    for (int k = 0; k < 4; k++) begin
      px[k] = longint'($signed(p.x[k]));
      py[k] = longint'($signed(p.y[k]));
    end
    for (int k = 0; k < 4; k++) begin
      s = dist_sum(px, py, px[k] * 256, py[k] * 256);
      if (s < best) best = s;
    end
    for (int k = 0; k < 3; k++) begin
      a1 = py[pr[k][1]] - py[pr[k][0]];
      b1 = px[pr[k][0]] - px[pr[k][1]];
      c1 = px[pr[k][1]] * py[pr[k][0]] - px[pr[k][0]] * py[pr[k][1]];
      a2 = py[pr[k][3]] - py[pr[k][2]];
      b2 = px[pr[k][2]] - px[pr[k][3]];
      c2 = px[pr[k][3]] * py[pr[k][2]] - px[pr[k][2]] * py[pr[k][3]];
      det = a1 * b2 - a2 * b1;
      if (det == 0) begin
        cx = 0;
        cy = 0;
      end else begin
        cx = clamp_q16(((b1 * c2 - b2 * c1) * 256) / det);
        cy = clamp_q16(((a2 * c1 - a1 * c2) * 256) / det);
      end
      s = dist_sum(px, py, cx, cy);
      if (s < best) best = s;
    end
    return best[31:0];
  endfunction

  function automatic pts_t mk(int ax, int ay, int bx, int by, int qx, int qy,
                              int dx, int dy);
    pts_t p;
    p.x = '{ax[15:0], bx[15:0], qx[15:0], dx[15:0]};
    p.y = '{ay[15:0], by[15:0], qy[15:0], dy[15:0]};
    p.has_lit = 1'b0;
    p.lit = '0;
    return p;
  endfunction

  function automatic pts_t mk_lit(pts_t p, logic [31:0] v);
    p.has_lit = 1'b1;
    p.lit = v;
    return p;
  endfunction

  function automatic pts_t rand_pts();
    pts_t p;
    int   mode, cx0, cy0, r, sx, sy;
    mode = $urandom_range(9);
    cx0 = $urandom_range(65535) - 32768;
    cy0 = $urandom_range(65535) - 32768;
    r = (mode < 4) ? $urandom_range(1023) + 1 : 32768;
    for (int k = 0; k < 4; k++) begin
      if (mode < 4) begin
        p.x[k] = 16'(cx0 + $urandom_range(2 * r) - r);
        p.y[k] = 16'(cy0 + $urandom_range(2 * r) - r);
      end else begin
        p.x[k] = 16'($urandom);
        p.y[k] = 16'($urandom);
      end
    end
    if (mode == 8) begin
      sx = $urandom_range(64) - 32;
      sy = $urandom_range(64) - 32;
      for (int k = 0; k < 4; k++) begin
        p.x[k] = 16'(cx0 / 4 + k * sx * ($urandom_range(3) + 1));
        p.y[k] = 16'(cy0 / 4 + k * sy * ($urandom_range(3) + 1));
      end
    end else if (mode == 9) begin
      p.x[3] = 16'(p.x[2] + p.x[1] - p.x[0]);
      p.y[3] = 16'(p.y[2] + p.y[1] - p.y[0]);
    end
    p.has_lit = 1'b0;
    p.lit = '0;
    return p;
  endfunction

  task automatic send_pts(pts_t p);
    while ($urandom_range(99) < push_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    {pa_x, pb_x, pc_x, pd_x} <= {p.x[0], p.x[1], p.x[2], p.x[3]};
    {pa_y, pb_y, pc_y, pd_y} <= {p.y[0], p.y[1], p.y[2], p.y[3]};
    do @(posedge clk); while (full);
    median_q.push_back(p.has_lit ? p.lit : least_distance(p));
  endtask

  initial begin
    dir_tab.push_back(mk_lit(mk(0, 0, 0, 0, 0, 0, 0, 0), 32'd0));
    dir_tab.push_back(mk_lit(mk(256, 0, 256, 0, 256, 0, 256, 0), 32'd0));
    dir_tab.push_back(mk_lit(mk(0, 0, 256, 0, 0, 0, 256, 0), 32'h0002_0000));
    dir_tab.push_back(mk(0, 0, 256, 0, 256, 256, 0, 256));
    dir_tab.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    dir_tab.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768));
    dir_tab.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 32767));
    dir_tab.push_back(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    dir_tab.push_back(mk(0, 0, 256, 0, 0, 256, 256, 256));
    dir_tab.push_back(mk(0, 0, 256, 256, 512, 512, 768, 768));
    dir_tab.push_back(mk(0, 0, 100, 1, 0, 10, 100, 11));
    dir_tab.push_back(mk(0, 0, 32767, 1, 0, 2, 32767, 2));
    dir_tab.push_back(mk(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
    dir_tab.push_back(mk(100, 200, -300, 400, 500, -600, -700, -800));
    dir_tab.push_back(mk(-21846, 21845, 21845, -21846, 0, 0, 1, -1));
    dir_tab.push_back(mk(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) send_pts(dir_tab[i]);
    for (int n = 0; n < NumRand; n++) begin
      if (n == NumRand / 3) begin
        push_idle = 59;
        pop_idle = 19;
        push <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
      end else if (n == 2 * NumRand / 3) begin
        push_idle = 0;
        pop_idle = 0;
      end
      send_pts(rand_pts());
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (median_q.size() == 0) begin
          $error("min_total_distance: unexpected transfer, actual %0d", min_total_distance);
          err_cnt++;
        end else begin
          if (min_total_distance !== median_q[0]) begin
            $error("min_total_distance: expected %0d actual %0d", median_q[0],
                   min_total_distance);
            err_cnt++;
          end
          void'(median_q.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= pop_idle);
    end
  end

  initial begin
    wait (stim_done);
    while (median_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_cnt == 0 && median_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
